// ===== rtl/bdc_pkg.sv =====
// Package for the B-dot detumble controller: field widths, register indexes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bdc_pkg;

  localparam int FIELD_W    = 16;
  localparam int DT_W       = 16;
  localparam int RATE_W     = 33;
  localparam int GAIN_W     = 32;
  localparam int GAIN_FRAC  = 16;
  localparam int DIPMAX_W   = 15;
  localparam int TAU_W      = 16;
  localparam int DEN_W      = 17;
  localparam int SUM_W      = 35;
  localparam int SUM_MAG_W  = 34;
  localparam int FILT_NUM_W = SUM_MAG_W + TAU_W;
  localparam int CFG_IDX_W  = 2;
  localparam int MUL_LO_W   = 17;
  localparam int MUL_HI_W   = RATE_W - MUL_LO_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF_TAU   = 2'd2;

  localparam logic [DIPMAX_W-1:0] DIP_LIMIT_RST = 15'h7FFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW_DIV,
    ST_FILT_MUL,
    ST_FILT_GO,
    ST_FILT_DIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_WAIT_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic raw_done;
    logic filt_mul;
    logic filt_start;
    logic filt_done;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic prime;
    logic dt_zero;
    logic filt_en;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/bdc_if.sv =====
// Valid/ready channel interfaces for the B-dot detumble controller.
// Depends on bdc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface bdc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bdc_pkg::FIELD_W-1:0]  mag_x;
  logic signed [bdc_pkg::FIELD_W-1:0]  mag_y;
  logic signed [bdc_pkg::FIELD_W-1:0]  mag_z;
  logic        [bdc_pkg::DT_W-1:0]     interval;
  logic                                restart;

  modport source (output valid, mag_x, mag_y, mag_z, interval, restart, input ready);
  modport sink   (input valid, mag_x, mag_y, mag_z, interval, restart, output ready);
endinterface

interface bdc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bdc_pkg::FIELD_W-1:0] dipole_x;
  logic signed [bdc_pkg::FIELD_W-1:0] dipole_y;
  logic signed [bdc_pkg::FIELD_W-1:0] dipole_z;
  logic signed [bdc_pkg::RATE_W-1:0]  rate_x;
  logic signed [bdc_pkg::RATE_W-1:0]  rate_y;
  logic signed [bdc_pkg::RATE_W-1:0]  rate_z;
  logic signed [bdc_pkg::RATE_W-1:0]  eff_rate_x;
  logic signed [bdc_pkg::RATE_W-1:0]  eff_rate_y;
  logic signed [bdc_pkg::RATE_W-1:0]  eff_rate_z;
  logic                               first_sample;

  modport source (output valid, dipole_x, dipole_y, dipole_z, rate_x, rate_y, rate_z,
                  eff_rate_x, eff_rate_y, eff_rate_z, first_sample, input ready);
  modport sink   (input valid, dipole_x, dipole_y, dipole_z, rate_x, rate_y, rate_z,
                  eff_rate_x, eff_rate_y, eff_rate_z, first_sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdot_detumble_controller.sv =====
// B-dot detumble controller, top level.
// Takes one magnetometer beat (mag_x/y/z, interval, restart) on in_ch and returns
// one result beat on out_ch: dipole command, raw and effective field rates and the
// first_sample flag. A beat with interval zero is consumed and gives no result.
// A priming sample goes straight to the output register; other samples pass
// through the per-axis bit-serial dividers (raw rate, then filter quotient if
// hpf_tau is nonzero) and the three-step dipole multiply. The axes run in parallel.
// One item is in work at a time; the next input beat is taken the cycle after the
// result has moved to the output register. A stalled receiver lets one more item
// finish and then holds off the input. Registers are written through
// cfg_we/cfg_idx/cfg_data; the user must write them only while idle, as the block
// itself does not enforce this. A synchronous reset (rst_n low) sets gain 0, the
// dipole limit to 32767, hpf_tau 0, clears the pending result and makes the next
// sample a priming sample.
// Depends on bdc_pkg, bdc_if, bdc_div, bdc_datapath and bdc_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module bdot_detumble_controller #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bdc_in_if.sink                        in_ch,
  bdc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bdc_pkg::GAIN_W-1:0]    cfg_data
);
  import bdc_pkg::*;

  cmd_t                      cmd;
  sts_t                      sts;
  logic signed [FIELD_W-1:0] mag_w [3];
  logic signed [FIELD_W-1:0] dip_w [3];
  logic signed [RATE_W-1:0]  rate_w [3];
  logic signed [RATE_W-1:0]  eff_w [3];
  logic                      first_w;

  assign mag_w[0] = in_ch.mag_x;
  assign mag_w[1] = in_ch.mag_y;
  assign mag_w[2] = in_ch.mag_z;

  bdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .mag_in   (mag_w),
    .interval (in_ch.interval),
    .restart  (in_ch.restart),
    .cmd      (cmd),
    .sts      (sts),
    .dipole_o (dip_w),
    .rate_o   (rate_w),
    .eff_o    (eff_w),
    .first_o  (first_w)
  );

  assign out_ch.dipole_x     = dip_w[0];
  assign out_ch.dipole_y     = dip_w[1];
  assign out_ch.dipole_z     = dip_w[2];
  assign out_ch.rate_x       = rate_w[0];
  assign out_ch.rate_y       = rate_w[1];
  assign out_ch.rate_z       = rate_w[2];
  assign out_ch.eff_rate_x   = eff_w[0];
  assign out_ch.eff_rate_y   = eff_w[1];
  assign out_ch.eff_rate_z   = eff_w[2];
  assign out_ch.first_sample = first_w;

endmodule
`default_nettype wire

// ===== rtl/bdc_div.sv =====
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
// Standalone; used by bdc_datapath, one per axis.
`timescale 1ns / 1ps
`default_nettype none
module bdc_div #(
  parameter int NW = 50,
  parameter int DW = 17,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [CW-1:0] steps,
  output logic [NW-1:0] quo,
  output logic          done
);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      q_nxt    = {q_r[NW-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== rtl/bdc_datapath.sv =====
// Datapath: configuration registers, per-axis state, dividers, filter and dipole
// multipliers, and the result register. Depends on bdc_pkg and bdc_div.
`timescale 1ns / 1ps
`default_nettype none
module bdc_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bdc_pkg::GAIN_W-1:0]         cfg_data,
  input  logic signed [bdc_pkg::FIELD_W-1:0] mag_in [3],
  input  logic [bdc_pkg::DT_W-1:0]           interval,
  input  logic                               restart,
  input  bdc_pkg::cmd_t                      cmd,
  output bdc_pkg::sts_t                      sts,
  output logic signed [bdc_pkg::FIELD_W-1:0] dipole_o [3],
  output logic signed [bdc_pkg::RATE_W-1:0]  rate_o [3],
  output logic signed [bdc_pkg::RATE_W-1:0]  eff_o [3],
  output logic                               first_o
);
  import bdc_pkg::*;

  localparam int RAW_W  = FIELD_W + FRAC_BITS;
  localparam int DIV_W  = (RAW_W > FILT_NUM_W) ? RAW_W : FILT_NUM_W;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int SHIFT  = GAIN_FRAC + FRAC_BITS;
  localparam int PROD_W = GAIN_W + RATE_W;
  localparam int Q_W    = PROD_W - SHIFT;

  logic [GAIN_W-1:0]   gain_r;
  logic [DIPMAX_W-1:0] maxd_r;
  logic [TAU_W-1:0]    tau_r;
  logic                primed_r;
  logic [DT_W-1:0]     dt_r;
  logic                first_r;
  logic                out_first_r;
  logic [2:0]          done_w;

  logic                div_start;
  logic [CNT_W-1:0]    div_steps;
  logic [DEN_W-1:0]    div_den;

  function automatic logic signed [RATE_W-1:0] sat_rate(input logic neg,
                                                        input logic [DIV_W-1:0] mag);
    logic [DIV_W-1:0]        lim;
    logic signed [RATE_W-1:0] res;
    lim = (DIV_W'(1) << (RATE_W - 1)) - (neg ? DIV_W'(0) : DIV_W'(1));
    if (mag > lim) begin
      res = neg ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    end else begin
      res = neg ? (~mag[RATE_W-1:0] + 1'b1) : mag[RATE_W-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      maxd_r <= DIP_LIMIT_RST;
      tau_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GAIN:      gain_r <= cfg_data;
        CFG_DIP_LIMIT: maxd_r <= cfg_data[DIPMAX_W-1:0];
        CFG_HPF_TAU:   tau_r  <= cfg_data[TAU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
    end else if (cmd.load) begin
      primed_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r    <= interval;
      first_r <= sts.prime;
    end
    if (cmd.out_load) begin
      out_first_r <= first_r;
    end
  end

  assign sts.prime    = restart | ~primed_r;
  assign sts.dt_zero  = (interval == '0);
  assign sts.filt_en  = (tau_r != '0);
  assign sts.div_done = &done_w;

  assign div_start = (cmd.load & ~sts.prime) | cmd.filt_start;
  assign div_steps = cmd.filt_start ? CNT_W'(DIV_W) : CNT_W'(RAW_W);
  assign div_den   = cmd.filt_start ? (DEN_W'(tau_r) + DEN_W'(dt_r)) : DEN_W'(interval);

  assign first_o = out_first_r;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [FIELD_W-1:0]   prev_field_r;
    logic signed [RATE_W-1:0]    prev_raw_r;
    logic signed [RATE_W-1:0]    filt_r;
    logic signed [RATE_W-1:0]    raw_r;
    logic signed [RATE_W-1:0]    eff_r;
    logic                        raw_neg_r;
    logic                        sum_neg_r;
    logic [FILT_NUM_W-1:0]       fnum_r;
    logic [GAIN_W+MUL_LO_W-1:0]  plo_r;
    logic [GAIN_W+MUL_HI_W-1:0]  phi_r;
    logic signed [FIELD_W-1:0]   dip_r;
    logic signed [FIELD_W-1:0]   out_dip_r;
    logic signed [RATE_W-1:0]    out_raw_r;
    logic signed [RATE_W-1:0]    out_eff_r;

    logic signed [FIELD_W:0]     diff;
    logic [FIELD_W:0]            diff_abs;
    logic [DIV_W-1:0]            raw_num;
    logic [DIV_W-1:0]            div_num;
    logic [DIV_W-1:0]            quo;
    logic signed [RATE_W-1:0]    quo_sat;
    logic signed [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]            sum_abs;
    logic [RATE_W:0]             eff_abs;
    logic [PROD_W-1:0]           prod;
    logic [Q_W-1:0]              q;
    logic [DIPMAX_W-1:0]         q_cl;

    assign diff     = {mag_in[i][FIELD_W-1], mag_in[i]} -
                      {prev_field_r[FIELD_W-1], prev_field_r};
    assign diff_abs = diff[FIELD_W] ? (~diff + 1'b1) : diff;
    assign raw_num  = {diff_abs[FIELD_W-1:0], {(DIV_W-FIELD_W){1'b0}}};
    assign div_num  = cmd.filt_start ? DIV_W'(fnum_r) : raw_num;

    bdc_div #(
      .NW (DIV_W),
      .DW (DEN_W),
      .CW (CNT_W)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .quo   (quo),
      .done  (done_w[i])
    );

    assign quo_sat = sat_rate(cmd.filt_done ? sum_neg_r : raw_neg_r, quo);

    assign sum     = SUM_W'(filt_r) + SUM_W'(raw_r) - SUM_W'(prev_raw_r);
    assign sum_abs = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

    assign eff_abs = eff_r[RATE_W-1] ? ((RATE_W+1)'(0) - (RATE_W+1)'(eff_r))
                                     : {1'b0, eff_r};

    assign prod = PROD_W'(plo_r) + (PROD_W'(phi_r) << MUL_LO_W);
    assign q    = prod[PROD_W-1:SHIFT];
    assign q_cl = (q > Q_W'(maxd_r)) ? maxd_r : q[DIPMAX_W-1:0];

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        prev_field_r <= mag_in[i];
        raw_neg_r    <= diff[FIELD_W];
        if (sts.prime) begin
          prev_raw_r <= '0;
          filt_r     <= '0;
          raw_r      <= '0;
          eff_r      <= '0;
          dip_r      <= '0;
        end
      end
      if (cmd.raw_done) begin
        raw_r <= quo_sat;
        eff_r <= quo_sat;
      end
      if (cmd.filt_mul) begin
        fnum_r    <= sum_abs[SUM_MAG_W-1:0] * tau_r;
        sum_neg_r <= sum[SUM_W-1];
      end
      if (cmd.filt_done) begin
        filt_r     <= quo_sat;
        prev_raw_r <= raw_r;
        eff_r      <= quo_sat;
      end
      if (cmd.mul_lo) begin
        plo_r <= gain_r * eff_abs[MUL_LO_W-1:0];
      end
      if (cmd.mul_hi) begin
        phi_r <= gain_r * eff_abs[RATE_W-1:MUL_LO_W];
      end
      if (cmd.mul_sum) begin
        dip_r <= eff_r[RATE_W-1] ? $signed({1'b0, q_cl}) : -$signed({1'b0, q_cl});
      end
      if (cmd.out_load) begin
        out_dip_r <= dip_r;
        out_raw_r <= raw_r;
        out_eff_r <= eff_r;
      end
    end

    assign dipole_o[i] = out_dip_r;
    assign rate_o[i]   = out_raw_r;
    assign eff_o[i]    = out_eff_r;
  end

endmodule
`default_nettype wire

// ===== rtl/bdc_ctrl.sv =====
// Controller FSM: sequences division, filter and dipole steps, owns the
// channel handshakes and the result valid flag. Depends on bdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bdc_pkg::sts_t sts,
  output bdc_pkg::cmd_t cmd
);
  import bdc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;

  assign in_fire  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !sts.dt_zero) begin
          state_nxt = sts.prime ? ST_WAIT_OUT : ST_RAW_DIV;
        end
      end
      ST_RAW_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.filt_en ? ST_FILT_MUL : ST_MUL_LO;
        end
      end
      ST_FILT_MUL: state_nxt = ST_FILT_GO;
      ST_FILT_GO:  state_nxt = ST_FILT_DIV;
      ST_FILT_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_MUL_SUM;
      ST_MUL_SUM:  state_nxt = ST_WAIT_OUT;
      ST_WAIT_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    cmd            = '0;
    cmd.load       = in_fire & ~sts.dt_zero;
    cmd.raw_done   = (state_r == ST_RAW_DIV) & sts.div_done;
    cmd.filt_mul   = (state_r == ST_FILT_MUL);
    cmd.filt_start = (state_r == ST_FILT_GO);
    cmd.filt_done  = (state_r == ST_FILT_DIV) & sts.div_done;
    cmd.mul_lo     = (state_r == ST_MUL_LO);
    cmd.mul_hi     = (state_r == ST_MUL_HI);
    cmd.mul_sum    = (state_r == ST_MUL_SUM);
    cmd.out_load   = (state_r == ST_WAIT_OUT) & out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
